// ----- rtl/ncv_pkg.sv -----
// ----------------------------------------------------------------------------
// NMEA checksum verify package
// Character constants, the per-sentence state type and the character
// classification helpers.
// ----------------------------------------------------------------------------
package ncv_pkg;

	localparam int MAX_SENTENCE_DEF = 149;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam int MIN_LEN = 4;

	// Running state of one sentence; tail[0] is the newest byte.
	typedef struct packed {
		logic [7:0]       running_xor;
		logic [3:0][7:0]  tail;
		logic [7:0]       count;
		logic             bad;
	} sent_state_t;

	// Hex digit decode: bit 4 marks a valid hex character.
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic logic is_alnum(input logic [7:0] c);
		logic r;
		r = ((c >= 8'h30) && (c <= 8'h39)) ||
		    ((c >= 8'h41) && (c <= 8'h5A)) ||
		    ((c >= 8'h61) && (c <= 8'h7A));
		return r;
	endfunction

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r = '0;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 8'h30);
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 8'h37);
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 8'h57);
		end
		return r;
	endfunction

endpackage

// ----- rtl/ncv_eval.sv -----
// ----------------------------------------------------------------------------
// NMEA checksum verify: final-byte evaluation
// Combines the stored sentence state with the final byte and produces the
// checksum and the pass/fail verdict.
// ----------------------------------------------------------------------------
module ncv_eval #(
	parameter int MAX_SENTENCE = ncv_pkg::MAX_SENTENCE_DEF
) (
	input  ncv_pkg::sent_state_t st,
	input  logic [7:0]           char_in,
	output logic                 valid_res,
	output logic [7:0]           computed_sum
);

	logic [8:0]    n;
	logic [8:0]    len;
	logic          strip;
	logic [7:0]    x;
	logic [7:0]    d1;
	logic [7:0]    d2;
	logic [7:0]    hex_value;
	logic          long_enough;
	ncv_pkg::hex_t h1;
	ncv_pkg::hex_t h2;

	assign strip = (char_in == ncv_pkg::CH_LF) || (char_in == ncv_pkg::CH_CR) ||
	               (char_in == ncv_pkg::CH_SPACE);
	assign n     = {1'b0, st.count} + 9'd1;
	assign len   = strip ? (n - 9'd1) : n;
	assign x     = (st.count != 8'd0) ? (st.running_xor ^ char_in) : st.running_xor;
	assign long_enough = (len >= 9'(ncv_pkg::MIN_LEN));

	assign d1 = strip ? st.tail[1] : st.tail[0];
	assign d2 = strip ? st.tail[0] : char_in;
	assign h1 = ncv_pkg::hex_decode(d1);
	assign h2 = ncv_pkg::hex_decode(d2);

	// Hex decoding stops at the first character that is not a hex digit.
	always_comb begin
		hex_value = 8'd0;
		if (h1.ok) begin
			hex_value = h2.ok ? {h1.val, h2.val} : {4'd0, h1.val};
		end
	end

	always_comb begin
		computed_sum = 8'd0;
		if (long_enough) begin
			computed_sum = strip ? (x ^ st.tail[2] ^ st.tail[1] ^ st.tail[0] ^ char_in)
			                     : (x ^ st.tail[1] ^ st.tail[0] ^ char_in);
		end
	end

	assign valid_res = !st.bad && (char_in != ncv_pkg::CH_NUL) && long_enough &&
	                   (len <= 9'(MAX_SENTENCE)) &&
	                   ncv_pkg::is_alnum(d1) && ncv_pkg::is_alnum(d2) &&
	                   (hex_value == computed_sum);

endmodule

// ----- rtl/nmea_checksum_verify.sv -----
// ----------------------------------------------------------------------------
// NMEA checksum verify
// Streams one sentence byte by byte and reports whether its trailing hex
// checksum matches the XOR of the covered characters.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one sentence byte per transfer in s_tdata, with
// s_tlast high on the final byte. A single trailing newline, carriage
// return or space on that final byte is dropped before checking.
// For every final byte one result transfer leaves on the master channel:
// m_tdata[0] is the verdict, m_tdata[8:1] the XOR of the covered bytes.
// A byte is held in an input register and combined with the running
// sentence state there, so a result is loaded into the output register
// when its final byte leaves the input register.
// One byte is taken every cycle unless a final byte waits in the input
// register; the running XOR and tail shift update as each byte leaves it.
// When the receiver stalls, the result stays in the output register; bytes
// that are not final keep flowing, and a final byte waits in the input
// register until the output register frees up.
// Reset (arst_n low) clears the sentence state and the valid flags of the
// input and output registers at once.
// ----------------------------------------------------------------------------
module nmea_checksum_verify #(
	parameter int MAX_SENTENCE = ncv_pkg::MAX_SENTENCE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] valid_res, [8:1] computed_sum, [15:9] zero
);

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 last_s1;
	ncv_pkg::sent_state_t st_q;
	logic                 out_valid_q;
	logic                 res_valid_q;
	logic [7:0]           res_sum_q;
	logic                 out_free;
	logic                 s1_go;
	logic                 eval_valid;
	logic [7:0]           eval_sum;

	assign out_free = !out_valid_q || m_tready;
	// Bytes that produce no result never wait on the output side.
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				st_q <= '0;
			end else begin
				if (st_q.count != 8'd0) begin
					st_q.running_xor <= st_q.running_xor ^ char_s1;
				end
				st_q.tail <= {st_q.tail[2:0], char_s1};
				if (st_q.count != 8'hFF) begin
					st_q.count <= st_q.count + 8'd1;
				end
				if ((char_s1 == ncv_pkg::CH_NUL) || (st_q.count == 8'hFF)) begin
					st_q.bad <= 1'b1;
				end
			end
		end
	end

	ncv_eval #(
		.MAX_SENTENCE(MAX_SENTENCE)
	) u_eval (
		.st          (st_q),
		.char_in     (char_s1),
		.valid_res   (eval_valid),
		.computed_sum(eval_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_go && last_s1) begin
			res_valid_q <= eval_valid;
			res_sum_q   <= eval_sum;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, res_sum_q, res_valid_q};

	// A final byte clears the sentence state on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (st_q.count == 8'd0 && !st_q.bad))
		else $error("sentence state not cleared after final byte");

	// A new result only appears after a final byte left the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_go && last_s1))
		else $error("result without a final byte");

	// A byte waiting in the input register is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> (valid_s1 && $stable(char_s1) && $stable(last_s1)))
		else $error("input register overwritten while waiting");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA checksum verify testbench
// Streams sentences into the checker byte by byte, predicts each verdict and
// XOR locally, and compares every result transfer against the oldest
// prediction. Directed sentences cover framing, tail decoding and bad bytes.
// Random traffic then mixes well-formed, corrupted, noisy and overlong
// sentences under several sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb;

	localparam int         CLK_HALF  = 2;
	localparam int         MAX_LEN   = ncv_pkg::MAX_SENTENCE_DEF;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic       ok;
		logic [7:0] sum;
	} verdict_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	// Local copy of the sentence state; tail[0] is the newest byte.
	logic [7:0]       sent_xor  = '0;
	logic [3:0][7:0]  sent_tail = '0;
	logic [7:0]       sent_len  = '0;
	logic             sent_bad  = 1'b0;

	verdict_t verdict_q[$];
	int       errors        = 0;
	int       send_idle_pct = 0;
	int       sink_stall_pct = 0;

	nmea_checksum_verify #(
		.MAX_SENTENCE(MAX_LEN)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic bit is_tail_char(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
	endfunction

	// Returns the nibble value of a hex character, or -1 when it is not hex.
	function automatic int hex_nibble(input logic [7:0] c);
		if (c inside {[8'h30:8'h39]})
			return int'(c) - 'h30;
		if (c inside {[8'h41:8'h46]})
			return int'(c) - 'h41 + 10;
		if (c inside {[8'h61:8'h66]})
			return int'(c) - 'h61 + 10;
		return -1;
	endfunction

	// Folds one accepted byte into the sentence state; a final byte queues
	// the expected verdict and clears the state.
	function automatic void absorb_byte(input logic [7:0] c, input logic fin);
		logic [7:0] x;
		logic [7:0] s;
		logic [7:0] d1;
		logic [7:0] d2;
		int         len;
		int         h1;
		int         h2;
		int         v;
		bit         strip;
		bit         ok;
		x = sent_xor;
		s = '0;
		v = 0;
		if (c == ncv_pkg::CH_NUL)
			sent_bad = 1'b1;
		if (sent_len != 0)
			x ^= c;
		if (!fin) begin
			sent_xor  = x;
			sent_tail = {sent_tail[2:0], c};
			if (sent_len == 8'hFF)
				sent_bad = 1'b1;
			else
				sent_len++;
			return;
		end
		strip = (c == ncv_pkg::CH_LF) || (c == ncv_pkg::CH_CR) || (c == ncv_pkg::CH_SPACE);
		len   = int'(sent_len) + 1 - (strip ? 1 : 0);
		ok    = !sent_bad && (len >= ncv_pkg::MIN_LEN) && (len <= MAX_LEN);
		if (len >= ncv_pkg::MIN_LEN) begin
			if (strip) begin
				s  = x ^ sent_tail[2] ^ sent_tail[1] ^ sent_tail[0] ^ c;
				d1 = sent_tail[1];
				d2 = sent_tail[0];
			end else begin
				s  = x ^ sent_tail[1] ^ sent_tail[0] ^ c;
				d1 = sent_tail[0];
				d2 = c;
			end
			if (!is_tail_char(d1) || !is_tail_char(d2))
				ok = 1'b0;
			h1 = hex_nibble(d1);
			h2 = hex_nibble(d2);
			if (h1 >= 0)
				v = (h2 >= 0) ? h1 * 16 + h2 : h1;
			if (v[7:0] != s)
				ok = 1'b0;
		end
		verdict_q.push_back('{ok: ok, sum: s});
		sent_xor  = '0;
		sent_tail = '0;
		sent_len  = '0;
		sent_bad  = 1'b0;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	// Valid is left high after the transfer, so back-to-back bytes follow without a gap.
	task automatic send_byte(input logic [7:0] c, input logic fin);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		absorb_byte(c, fin);
		@(negedge clk);
	endtask

	task automatic send_sentence(input byte_q_t q);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	function automatic byte_q_t from_text(input string txt);
		byte_q_t q;
		for (int i = 0; i < txt.len(); i++)
			q.push_back(txt[i]);
		return q;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 10)
			return 8'h30 + 8'(n);
		return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	// Builds "$<body>*hh" with an optional terminator; corrupt replaces one
	// checksum character with an arbitrary printable one.
	function automatic byte_q_t make_sentence(input int body_len, input bit corrupt);
		byte_q_t    q;
		logic [7:0] ck;
		logic [7:0] ch;
		bit         upper;
		int         term;
		ck    = '0;
		upper = 1'($urandom_range(1));
		term  = int'($urandom_range(5));
		q.push_back(CH_DOLLAR);
		for (int i = 0; i < body_len; i++) begin
			ch = 8'($urandom_range(8'h7E, 8'h20));
			ck ^= ch;
			q.push_back(ch);
		end
		q.push_back(CH_STAR);
		q.push_back(hex_char(ck[7:4], upper));
		q.push_back(hex_char(ck[3:0], upper));
		if (corrupt)
			q[q.size() - 1 - $urandom_range(1)] = 8'($urandom_range(8'h7E, 8'h21));
		case (term)
			1: q.push_back(ncv_pkg::CH_LF);
			2: q.push_back(ncv_pkg::CH_CR);
			3: q.push_back(ncv_pkg::CH_SPACE);
			default: ;
		endcase
		return q;
	endfunction

	task automatic test_framing();
		send_sentence(from_text("\n"));       // empty after the strip
		send_sentence(from_text("$*00"));     // shortest sentence that passes
		send_sentence(from_text("$~*7e "));   // trailing space, lowercase digits
		send_sentence(from_text("$~*7E\r"));
	endtask

	task automatic test_tail_decode();
		send_sentence(from_text("$*g0"));     // first digit not hex decodes as zero
		send_sentence(from_text("$*0z"));     // decoding stops after one digit
		send_sentence(from_text("$x*0x"));
		send_sentence(from_text("$*-0"));     // tail character not alphanumeric
	endtask

	task automatic test_zero_byte();
		byte_q_t q;
		q = from_text("$*00");
		q.insert(1, ncv_pkg::CH_NUL);
		send_sentence(q);
	endtask

	task automatic test_random_traffic(input int n_bytes, input int idle_pct,
	                                   input int stall_pct);
		byte_q_t q;
		int      done;
		int      pick;
		send_idle_pct  = idle_pct;
		sink_stall_pct = stall_pct;
		done = 0;
		while (done < n_bytes) begin
			q.delete();
			pick = $urandom_range(99);
			if (pick < 2) begin
				// Around the length limit, or past the point where the count saturates.
				if ($urandom_range(1))
					q = make_sentence($urandom_range(155, 140), $urandom_range(3) == 0);
				else
					q = make_sentence($urandom_range(300, 250), 1'b0);
			end else if (pick < 75) begin
				q = make_sentence($urandom_range(20, 0), $urandom_range(4) == 0);
			end else begin
				repeat ($urandom_range(8, 1))
					q.push_back(8'($urandom_range(255)));
			end
			send_sentence(q);
			done += q.size();
		end
	endtask

	// Receiver back-pressure.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$error("result with nothing expected: valid_res=%0d computed_sum=0x%02h",
				       m_tdata[0], m_tdata[8:1]);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata[0] !== want.ok) begin
					$error("valid_res: expected %0d, got %0d", want.ok, m_tdata[0]);
					errors++;
				end
				if (m_tdata[8:1] !== want.sum) begin
					$error("computed_sum: expected 0x%02h, got 0x%02h", want.sum,
					       m_tdata[8:1]);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_framing();
		test_tail_decode();
		test_zero_byte();
		test_random_traffic(375, 0, 0);
		test_random_traffic(375, 62, 0);
		test_random_traffic(375, 0, 62);
		test_random_traffic(375, 25, 25);
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (verdict_q.size() != 0) begin
			$error("%0d expected results never arrived", verdict_q.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("tb: FAIL");
		$finish;
	end

endmodule
